@@ sv/mmvd_pkg.sv @@
// Shared types and constants of the multi-metric vector distance block.
`timescale 1ns / 1ps
package mmvd_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned DistW = 38;
  localparam int unsigned SqW = 56;
  localparam int unsigned NormW = 56;
  localparam int unsigned AbsW = 40;
  localparam int unsigned MaxW = 33;
  localparam int unsigned TermW = 50;
  localparam int unsigned NormTermW = 47;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [SqW-1:0] OneQ = SqW'(1) << FracBits;
  localparam logic RegMetricMode = 1'b0;

  typedef enum logic [1:0] {
    MODE_EUCLID,
    MODE_MANHATTAN,
    MODE_CHEBYSHEV,
    MODE_COSINE
  } metric_e;

  typedef struct packed {
    logic signed [SqW-1:0] sq;
    logic [NormW-1:0] na;
    logic [NormW-1:0] nb;
    logic [AbsW-1:0] abs_sum;
    logic [MaxW-1:0] peak_diff;
    logic clip;
  } sums_t;
endpackage

@@ sv/mmvd_if.sv @@
// Stream interfaces for coordinate pairs and distance results.
`timescale 1ns / 1ps
interface mmvd_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] coord_a;
  logic signed [31:0] coord_b;
  logic last_element;
  modport source (output valid, coord_a, coord_b, last_element, input ready);
  modport sink (input valid, coord_a, coord_b, last_element, output ready);
endinterface

interface mmvd_out_if;
  logic valid;
  logic ready;
  logic [37:0] distance;
  logic saturated;
  logic zero_norm;
  modport source (output valid, distance, saturated, zero_norm, input ready);
  modport sink (input valid, distance, saturated, zero_norm, output ready);
endinterface

@@ sv/mmvd_front.sv @@
// Front pipeline: accepts coordinate pairs and keeps the running sums.
`timescale 1ns / 1ps
module mmvd_front import mmvd_pkg::*; #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmvd_in_if.sink    in_i,
  input  metric_e    mode_i,
  input  logic       q_full_i,
  output logic       push_o,
  output sums_t      push_data_o
);
  localparam int unsigned CntW = $clog2(MAX_DIM + 1);

  logic stall, en, acc, drop;
  logic [CntW-1:0] cnt_q;
  logic v0_q, v1_q;
  logic signed [CoordW-1:0] a0_q, b0_q;
  logic last0_q, drop0_q, last1_q, drop1_q;
  logic signed [TermW-1:0] term1_q;
  logic [NormTermW-1:0] na1_q, nb1_q;
  logic [MaxW-1:0] ad1_q;
  sums_t sums_q, sums_d;

  logic signed [CoordW:0] diff;
  logic [MaxW-1:0] ad;
  logic signed [63:0] pab, paa, pbb;
  logic [65:0] pdd;
  logic signed [TermW-1:0] term;

  logic signed [SqW:0] sq_sum;
  logic [NormW:0] na_sum, nb_sum;
  logic [AbsW:0] abs_sum;

  assign stall = v1_q & last1_q & q_full_i;
  assign en = ~stall;
  assign in_i.ready = en;
  assign acc = in_i.valid & en;
  assign drop = (cnt_q >= CntW'(MAX_DIM));

  assign diff = {a0_q[CoordW-1], a0_q} - {b0_q[CoordW-1], b0_q};
  assign ad = diff[CoordW] ? MaxW'(-diff) : MaxW'(diff);
  assign pab = a0_q * b0_q;
  assign paa = a0_q * a0_q;
  assign pbb = b0_q * b0_q;
  assign pdd = {33'd0, ad} * {33'd0, ad};
  assign term = (mode_i == MODE_COSINE) ? TermW'($signed(pab[63:FracBits]))
                                        : {1'b0, pdd[64:FracBits]};

  always_comb begin
    sums_d = sums_q;
    sq_sum = {sums_q.sq[SqW-1], sums_q.sq} + (SqW+1)'(term1_q);
    na_sum = {1'b0, sums_q.na} + (NormW+1)'(na1_q);
    nb_sum = {1'b0, sums_q.nb} + (NormW+1)'(nb1_q);
    abs_sum = {1'b0, sums_q.abs_sum} + (AbsW+1)'(ad1_q);
    if (drop1_q) begin
      sums_d.clip = 1'b1;
    end else begin
      if (sq_sum[SqW] != sq_sum[SqW-1]) begin
        sums_d.sq = sq_sum[SqW] ? {1'b1, {(SqW-1){1'b0}}} : {1'b0, {(SqW-1){1'b1}}};
        sums_d.clip = 1'b1;
      end else begin
        sums_d.sq = sq_sum[SqW-1:0];
      end
      if (na_sum[NormW]) begin
        sums_d.na = {NormW{1'b1}};
        sums_d.clip = 1'b1;
      end else begin
        sums_d.na = na_sum[NormW-1:0];
      end
      if (nb_sum[NormW]) begin
        sums_d.nb = {NormW{1'b1}};
        sums_d.clip = 1'b1;
      end else begin
        sums_d.nb = nb_sum[NormW-1:0];
      end
      if (abs_sum[AbsW]) begin
        sums_d.abs_sum = {AbsW{1'b1}};
        sums_d.clip = 1'b1;
      end else begin
        sums_d.abs_sum = abs_sum[AbsW-1:0];
      end
      if (ad1_q > sums_q.peak_diff) begin
        sums_d.peak_diff = ad1_q;
      end
    end
  end

  assign push_o = v1_q & last1_q & ~q_full_i;
  assign push_data_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      sums_q <= '0;
    end else if (en) begin
      v0_q <= acc;
      v1_q <= v0_q;
      if (acc) begin
        if (in_i.last_element) begin
          cnt_q <= '0;
        end else if (!drop) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (v1_q) begin
        sums_q <= last1_q ? '0 : sums_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q <= in_i.coord_a;
      b0_q <= in_i.coord_b;
      last0_q <= in_i.last_element;
      drop0_q <= drop;
      last1_q <= last0_q;
      drop1_q <= drop0_q;
      term1_q <= term;
      na1_q <= paa[62:FracBits];
      nb1_q <= pbb[62:FracBits];
      ad1_q <= ad;
    end
  end
endmodule

@@ sv/mmvd_queue.sv @@
// Two-entry queue of finished sums between the front and back parts.
`timescale 1ns / 1ps
module mmvd_queue import mmvd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  sums_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output sums_t data_o
);
  sums_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

@@ sv/mmvd_back.sv @@
// Back sequencer: multiply, square root and divide, as the metric needs, finish each distance.
`timescale 1ns / 1ps
module mmvd_back import mmvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  sums_t      q_data_i,
  input  metric_e    mode_i,
  output logic       pop_o,
  mmvd_out_if.source out_o
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DIV, S_OUT} state_e;

  state_e state_q;
  sums_t sums_q;
  metric_e mode_q;
  logic [5:0] cnt_q;
  logic [111:0] prod_q, rad_q, pp_sh, prod_d;
  logic [59:0] rem_q, rem_n, trial;
  logic [55:0] root_q, root_d, mag;
  logic [15:0] quo_q;
  logic [16:0] quo_d;
  logic [27:0] pa, pb;
  logic [55:0] pp;
  logic [DistW-1:0] dist_q;
  logic sat_q, zero_q, ge, abs_over;
  logic [SqW-2:0] s_pos;

  function automatic logic [SqW-1:0] cos_dist(input logic [16:0] q, input logic neg);
    cos_dist = neg ? OneQ + SqW'(q) : OneQ - SqW'(q);
  endfunction

  assign pop_o = (state_q == S_IDLE) & q_valid_i;
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.distance = dist_q;
  assign out_o.saturated = sat_q;
  assign out_o.zero_norm = zero_q;

  assign mag = sums_q.sq[SqW-1] ? 56'(-sums_q.sq) : 56'(sums_q.sq);
  assign s_pos = q_data_i.sq[SqW-1] ? '0 : q_data_i.sq[SqW-2:0];
  assign abs_over = (q_data_i.abs_sum > AbsW'(DistMax));

  assign pa = cnt_q[1] ? sums_q.na[55:28] : sums_q.na[27:0];
  assign pb = cnt_q[0] ? sums_q.nb[55:28] : sums_q.nb[27:0];
  assign pp = {28'd0, pa} * {28'd0, pb};
  always_comb begin
    case (cnt_q[1:0])
      2'd0: pp_sh = 112'(pp);
      2'd3: pp_sh = 112'(pp) << 56;
      default: pp_sh = 112'(pp) << 28;
    endcase
  end
  assign prod_d = prod_q + pp_sh;

  always_comb begin
    if (state_q == S_DIV) begin
      rem_n = {rem_q[58:0], 1'b0};
      trial = {4'b0000, root_q};
    end else begin
      rem_n = {rem_q[57:0], rad_q[111:110]};
      trial = {2'b00, root_q, 2'b01};
    end
    ge = (rem_n >= trial);
    root_d = {root_q[54:0], ge};
    quo_d = {quo_q, ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      dist_q <= '0;
      sat_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            sums_q <= q_data_i;
            mode_q <= mode_i;
            cnt_q <= '0;
            zero_q <= (mode_i == MODE_COSINE) && (q_data_i.na == '0 || q_data_i.nb == '0);
            sat_q <= q_data_i.clip | ((mode_i == MODE_MANHATTAN) & abs_over);
            prod_q <= '0;
            rem_q <= '0;
            root_q <= '0;
            quo_q <= '0;
            rad_q <= 112'(s_pos) << FracBits;
            unique case (mode_i)
              MODE_EUCLID: state_q <= S_SQRT;
              MODE_MANHATTAN: begin
                dist_q <= abs_over ? DistMax : DistW'(q_data_i.abs_sum);
                state_q <= S_OUT;
              end
              MODE_CHEBYSHEV: begin
                dist_q <= DistW'(q_data_i.peak_diff);
                state_q <= S_OUT;
              end
              default: begin
                if (q_data_i.na == '0 || q_data_i.nb == '0) begin
                  dist_q <= DistW'(OneQ);
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_MUL;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          prod_q <= prod_d;
          if (cnt_q == 6'd3) begin
            rad_q <= prod_d;
            cnt_q <= '0;
            state_q <= S_SQRT;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_SQRT: begin
          rad_q <= {rad_q[109:0], 2'b00};
          root_q <= root_d;
          if (cnt_q == 6'd55) begin
            cnt_q <= '0;
            rem_q <= 60'(mag);
            if (mode_q == MODE_EUCLID) begin
              dist_q <= DistW'(root_d);
              state_q <= S_OUT;
            end else if (root_d == '0 || mag >= root_d) begin
              dist_q <= DistW'(cos_dist(17'(OneQ), sums_q.sq[SqW-1]));
              state_q <= S_OUT;
            end else begin
              state_q <= S_DIV;
            end
          end else begin
            cnt_q <= cnt_q + 6'd1;
            rem_q <= ge ? rem_n - trial : rem_n;
          end
        end
        S_DIV: begin
          rem_q <= ge ? rem_n - trial : rem_n;
          quo_q <= quo_d[15:0];
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd15) begin
            dist_q <= DistW'(cos_dist(quo_d, sums_q.sq[SqW-1]));
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/multi_metric_vector_distance.sv @@
// Top level of the multi-metric vector distance block.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        coord_a, coord_b, last_element
//   out_o    out  valid/ready        distance, saturated, zero_norm
//   apb      in   psel/penable       metric_mode at byte address 0
//
// The front takes one coordinate pair per cycle unless stalled; sums go via operand and product
// registers to the queue. Back: Manhattan, Chebyshev, zero-norm cosine exit at once; Euclidean
// uses the square-root unit (one root bit per cycle); cosine shares it and adds the multiplier
// and the divider. A two-entry queue holds finished sums; the front stalls only with it full.
// Reset clears all sums, the count and the mode; no clearing pass is needed.
`timescale 1ns / 1ps
module multi_metric_vector_distance import mmvd_pkg::*; #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmvd_in_if.sink     in_i,
  mmvd_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  metric_e mode_q;
  logic push, q_full, q_valid, pop;
  sums_t push_data, q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMetricMode) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EUCLID;
    end else if (psel && penable && pwrite && paddr[2] == RegMetricMode) begin
      mode_q <= metric_e'(pwdata[1:0]);
    end
  end

  mmvd_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .in_i, .mode_i(mode_q), .q_full_i(q_full),
    .push_o(push), .push_data_o(push_data)
  );

  mmvd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_data)
  );

  mmvd_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .mode_i(mode_q),
    .pop_o(pop), .out_o
  );
endmodule

@@ sv/mmvd_checker.sv @@
// Port-level assertions for the multi-metric vector distance block.
`timescale 1ns / 1ps
module mmvd_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [37:0] distance_i,
  input logic        zero_norm_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic [2:0]  paddr_i,
  input logic [31:0] pwdata_i,
  input logic [31:0] prdata_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_i))
    else $error("result changed while stalled");

  a_zero_norm_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_norm_i |-> distance_i == 38'd65536)
    else $error("zero norm result is not 1.0");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && paddr_i[2] == 1'b0
    |=> paddr_i[2] != 1'b0 || prdata_i[1:0] == $past(pwdata_i[1:0]))
    else $error("metric mode readback mismatch");
endmodule

bind multi_metric_vector_distance mmvd_port_props u_mmvd_port_props (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .distance_i(out_o.distance), .zero_norm_i(out_o.zero_norm),
  .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
  .paddr_i(paddr), .pwdata_i(pwdata), .prdata_i(prdata)
);

@@ sim/mmvd_checker.sv @@
// Distance predictor and result checker for the multi-metric vector distance block.
`timescale 1ns / 1ps
module mmvd_checker import mmvd_pkg::*; #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmvd_in_if          in_ch,
  mmvd_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches_o,
  output int          pending_o,
  output int          pairs_o,
  output int          results_o,
  output int          sat_seen_o,
  output int          zero_norm_seen_o
);
  typedef struct {
    logic [DistW-1:0] distance;
    logic             saturated;
    logic             zero_norm;
  } dist_t;

  dist_t             dist_q[$];
  metric_e           mode;
  longint            dot_sq;
  longint unsigned   norm_a, norm_b, abs_sum, peak_abs;
  int unsigned       count;
  bit                clip;

  localparam longint SqHi = (longint'(1) << 55) - 1;
  localparam longint SqLo = -(longint'(1) << 55);
  localparam longint unsigned NormHi = (longint'(1) << 56) - 1;
  localparam longint unsigned AbsHi = (longint'(1) << 40) - 1;
  localparam longint unsigned One = longint'(1) << FracBits;

  assign pending_o = dist_q.size();

  function automatic longint unsigned root_floor(logic [127:0] x);
    longint unsigned r, c;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (longint'(1) << i);
      if ((128'(c) * 128'(c)) <= x) r = c;
    end
    return r;
  endfunction

  task automatic clear_sums();
    dot_sq = 0; norm_a = 0; norm_b = 0; abs_sum = 0; peak_abs = 0; count = 0; clip = 0;
  endtask

  task automatic take_pair(longint a, longint b, logic last);
    longint diff, term, s;
    longint unsigned ad, u, r, mag, q;
    logic [127:0] d128;
    dist_t e;
    if (count >= MAX_DIM) begin
      clip = 1;
    end else begin
      diff = a - b;
      ad = diff < 0 ? longint'(-diff) : diff;
      if (mode == MODE_COSINE) term = (a * b) >>> FracBits;
      else term = longint'((ad * ad) >> FracBits);
      s = dot_sq + term;
      if (s > SqHi) begin s = SqHi; clip = 1; end
      if (s < SqLo) begin s = SqLo; clip = 1; end
      dot_sq = s;
      u = norm_a + (longint'(a * a) >> FracBits);
      if (u > NormHi) begin u = NormHi; clip = 1; end
      norm_a = u;
      u = norm_b + (longint'(b * b) >> FracBits);
      if (u > NormHi) begin u = NormHi; clip = 1; end
      norm_b = u;
      u = abs_sum + ad;
      if (u > AbsHi) begin u = AbsHi; clip = 1; end
      abs_sum = u;
      if (ad > peak_abs) peak_abs = ad;
      count++;
    end
    if (!last) return;
    e.zero_norm = 0;
    d128 = 0;
    case (mode)
      MODE_EUCLID: d128 = root_floor(128'(dot_sq < 0 ? 0 : dot_sq) << FracBits);
      MODE_MANHATTAN: d128 = abs_sum;
      MODE_CHEBYSHEV: d128 = peak_abs;
      default: begin
        if (norm_a == 0 || norm_b == 0) begin
          d128 = One;
          e.zero_norm = 1;
        end else begin
          r = root_floor(128'(norm_a) * 128'(norm_b));
          mag = dot_sq < 0 ? longint'(-dot_sq) : dot_sq;
          if (r == 0 || mag >= r) q = One;
          else q = longint'((128'(mag) << FracBits) / 128'(r));
          d128 = dot_sq >= 0 ? One - q : One + q;
        end
      end
    endcase
    e.saturated = clip;
    if (d128 > 128'(DistMax)) begin
      d128 = DistMax;
      e.saturated = 1;
    end
    e.distance = d128[DistW-1:0];
    dist_q.push_back(e);
    clear_sums();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dist_t e;
    if (!rst_ni) begin
      mode = MODE_EUCLID;
      clear_sums();
      dist_q.delete();
      mismatches_o = 0; pairs_o = 0; results_o = 0; sat_seen_o = 0; zero_norm_seen_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(4 * RegMetricMode))
        mode = metric_e'(pwdata[1:0]);
      if (out_ch.valid && out_ch.ready) begin
        results_o++;
        if (out_ch.saturated) sat_seen_o++;
        if (out_ch.zero_norm) zero_norm_seen_o++;
        if (dist_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) $display("%0t: unexpected distance %h", $realtime,
                                           out_ch.distance);
        end else begin
          e = dist_q.pop_front();
          if (out_ch.distance !== e.distance || out_ch.saturated !== e.saturated ||
              out_ch.zero_norm !== e.zero_norm) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: distance exp %h/%b/%b got %h/%b/%b", $realtime,
                       e.distance, e.saturated, e.zero_norm,
                       out_ch.distance, out_ch.saturated, out_ch.zero_norm);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pairs_o++;
        take_pair(longint'(in_ch.coord_a), longint'(in_ch.coord_b), in_ch.last_element);
      end
    end
  end
endmodule

@@ sim/tb_multi_metric_vector_distance.sv @@
// Testbench top: stimulus, configuration writes and verdict for the distance block.
`timescale 1ns / 1ps
module tb_multi_metric_vector_distance;
  import mmvd_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches, pending, pairs, results, sat_seen, zn_seen;
  bit          pair_taken;
  bit          idle_on = 1;
  bit          hold_req = 0;
  int          sent = 0;

  mmvd_in_if  in_ch();
  mmvd_out_if out_ch();

  multi_metric_vector_distance DUT (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mmvd_checker u_checker (
    .clk_i, .rst_ni, .in_ch, .out_ch, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches_o(mismatches), .pending_o(pending), .pairs_o(pairs), .results_o(results),
    .sat_seen_o(sat_seen), .zero_norm_seen_o(zn_seen)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) pair_taken <= in_ch.valid && in_ch.ready;

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_ch.valid = 0; in_ch.coord_a = 0; in_ch.coord_b = 0; in_ch.last_element = 0;
  end

  initial begin
    out_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 0;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk_i);
      end else begin
        out_ch.ready = 1;
      end
    end
  end

  task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_ch.valid = 1; in_ch.coord_a = a; in_ch.coord_b = b; in_ch.last_element = last;
    do @(negedge clk_i); while (!pair_taken);
    in_ch.valid = 0;
    sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sd524288);
    endcase
  endfunction

  task automatic send_vector(int len);
    for (int i = 0; i < len; i++) send_pair(rand_coord(), rand_coord(), i == len - 1);
  endtask

  task automatic set_mode(metric_e m);
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0; paddr = 3'(4 * RegMetricMode); pwdata = 32'(m);
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  initial begin
    int len;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    send_pair(32'h8000_0000, 32'h7fff_ffff, 1);
    send_pair(32'h7fff_ffff, 32'h8000_0000, 0);
    send_pair(32'h0001_0000, 32'hffff_0000, 1);
    set_mode(MODE_MANHATTAN);
    send_pair(32'h8000_0000, 32'h7fff_ffff, 0);
    send_pair(32'h0000_0003, 32'h0000_0000, 1);
    set_mode(MODE_CHEBYSHEV);
    send_pair(32'h0000_0000, 32'h0000_0000, 0);
    send_pair(32'hffff_ffff, 32'h7fff_ffff, 1);
    set_mode(MODE_COSINE);
    send_pair(32'h0000_0000, 32'h0001_0000, 1);
    send_pair(32'h0000_0001, 32'h0000_0005, 1);
    send_pair(32'h0002_0000, 32'hfffe_0000, 1);
    send_pair(32'h0003_0000, 32'h0003_0000, 0);
    send_pair(32'h0001_0000, 32'h0001_0000, 1);
    send_pair(32'h8000_0000, 32'h8000_0000, 1);
    send_pair(32'h8000_0000, 32'h7fff_ffff, 1);

    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph < 4 ? metric_e'(ph) : metric_e'($urandom_range(0, 3)));
      if (ph == 1) begin
        hold_req = 1;
        repeat (12) send_pair(rand_coord(), rand_coord(), 1);
      end
      if (ph == 5) idle_on = 0;
      while (sent < 16 + (ph + 1) * 122) begin
        case ($urandom_range(0, 9))
          0: len = $urandom_range(60, 70);
          1, 2: len = 1;
          default: len = $urandom_range(2, 8);
        endcase
        send_vector(len);
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Sent %0d coordinate pairs over all four metrics, checked %0d distances",
             pairs, results);
    $display("Saturated results: %0d, zero-norm cosine results: %0d", sat_seen, zn_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/mmvd_pkg.sv
sv/mmvd_if.sv
sv/mmvd_front.sv
sv/mmvd_queue.sv
sv/mmvd_back.sv
sv/multi_metric_vector_distance.sv
sv/mmvd_checker.sv
sim/mmvd_checker.sv
sim/tb_multi_metric_vector_distance.sv
